>>> hdl/csg_pkg.sv
// Shared types and constants of the correction string generator.
package csg_pkg;

    // Lattice limits and field widths
    localparam int MAX_WIDTH  = 32;
    localparam int MAX_HEIGHT = 32;
    localparam int RESET_DIM  = 32;
    localparam int DIM_W      = 6;
    localparam int STAB_W     = 11;
    localparam int SITE_W     = STAB_W - 1;
    localparam int QUBIT_W    = 11;
    localparam int DIV_STEPS  = SITE_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic {
        PAULI_Z = 1'b0,
        PAULI_X = 1'b1
    } t_pauli;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic div_by_h;
        logic latch_x;
        logic setup;
        logic emit_nf;
        logic emit_x;
        logic emit_y;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic coincide;
        logic x_same;
        logic y_same;
        logic x_end;
        logic y_end;
    } t_status;

    // Saturate a written dimension into 2..maxv
    function automatic logic [DIM_W-1:0] clamp_dim(
        input logic [DIM_W-1:0] v,
        input logic [DIM_W-1:0] maxv
    );
        logic [DIM_W-1:0] res;
        if (v < DIM_W'(2)) begin
            res = DIM_W'(2);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

>>> hdl/csg_regs.sv
// Configuration registers (lattice width and height) behind the APB-style port.
module csg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [csg_pkg::ADDR_W-1:0]  paddr,
    input  logic [csg_pkg::DATA_W-1:0]  pwdata,
    output logic [csg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [csg_pkg::DIM_W-1:0]   o_width,
    output logic [csg_pkg::DIM_W-1:0]   o_height
);

    logic [csg_pkg::DIM_W-1:0] r_width;
    logic [csg_pkg::DIM_W-1:0] r_height;
    logic                      wr_en;
    csg_pkg::t_reg_idx         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = csg_pkg::t_reg_idx'(paddr[2]);

    // Write with saturation into the legal range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= csg_pkg::DIM_W'(csg_pkg::RESET_DIM);
            r_height <= csg_pkg::DIM_W'(csg_pkg::RESET_DIM);
        end else if (wr_en) begin
            unique case (reg_idx)
                csg_pkg::REG_WIDTH: begin
                    r_width <= csg_pkg::clamp_dim(pwdata[csg_pkg::DIM_W-1:0],
                                                  csg_pkg::DIM_W'(csg_pkg::MAX_WIDTH));
                end
                csg_pkg::REG_HEIGHT: begin
                    r_height <= csg_pkg::clamp_dim(pwdata[csg_pkg::DIM_W-1:0],
                                                   csg_pkg::DIM_W'(csg_pkg::MAX_HEIGHT));
                end
                default: begin
                    r_width <= r_width;
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            csg_pkg::REG_WIDTH:  prdata = csg_pkg::DATA_W'(r_width);
            csg_pkg::REG_HEIGHT: prdata = csg_pkg::DATA_W'(r_height);
            default:             prdata = '0;
        endcase
    end

    assign o_width  = r_width;
    assign o_height = r_height;

endmodule

>>> hdl/csg_ctrl.sv
// Controller state machine: sequences site division, set-up and the two correction runs.
module csg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  csg_pkg::t_status i_status,
    output csg_pkg::t_cmd    o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DIVW   = 9'b000000010,
        S_LATCHX = 9'b000000100,
        S_DIVH   = 9'b000001000,
        S_SETUP  = 9'b000010000,
        S_DECIDE = 9'b000100000,
        S_NOFLIP = 9'b001000000,
        S_XWALK  = 9'b010000000,
        S_YWALK  = 9'b100000000
    } t_state;

    t_state                   r_state, n_state;
    logic [csg_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                     r_out_valid, n_out_valid;
    logic                     out_free;
    logic                     cnt_last;
    logic                     emit;
    csg_pkg::t_cmd            cmd;

    assign out_free = !r_out_valid || i_out_ready;
    assign cnt_last = (r_cnt == csg_pkg::CNT_W'(csg_pkg::DIV_STEPS - 1));

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_cnt    = '0;
                    n_state  = S_DIVW;
                end
            end
            S_DIVW: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_cnt   = '0;
                    n_state = S_LATCHX;
                end
            end
            S_LATCHX: begin
                cmd.latch_x = 1'b1;
                n_state     = S_DIVH;
            end
            S_DIVH: begin
                cmd.div_step = 1'b1;
                cmd.div_by_h = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_cnt   = '0;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                cmd.setup = 1'b1;
                n_state   = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_status.coincide) begin
                    n_state = S_NOFLIP;
                end else if (i_status.x_same) begin
                    n_state = S_YWALK;
                end else begin
                    n_state = S_XWALK;
                end
            end
            S_NOFLIP: begin
                if (out_free) begin
                    cmd.emit_nf = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_XWALK: begin
                if (out_free) begin
                    cmd.emit_x = 1'b1;
                    if (i_status.x_end) begin
                        n_state = i_status.y_same ? S_IDLE : S_YWALK;
                    end
                end
            end
            S_YWALK: begin
                if (out_free) begin
                    cmd.emit_y = 1'b1;
                    if (i_status.y_end) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set on emit, drop once the transaction is taken
    assign emit = cmd.emit_nf | cmd.emit_x | cmd.emit_y;

    always_comb begin
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // An accepted pair always starts the division by width
    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DIVW))
        else $error("accepted pair did not start division");

    // Step counter stays within the division length
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= csg_pkg::CNT_W'(csg_pkg::DIV_STEPS - 1))
        else $error("division step counter out of range");

    // A new result only ever comes from an emitting state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_NOFLIP || $past(r_state) == S_XWALK
                                || $past(r_state) == S_YWALK))
        else $error("result raised outside an emitting state");

    // The counter is idle in the idle state and in both walk states
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XWALK || r_state == S_YWALK || r_state == S_IDLE) |-> (r_cnt == '0))
        else $error("step counter left running after division");

endmodule

>>> hdl/csg_dp.sv
// Datapath: two-lane bit-serial site divider, direction pick and qubit index arithmetic.
module csg_dp (
    input  logic                        i_clk,
    input  csg_pkg::t_cmd               i_cmd,
    input  logic [csg_pkg::DIM_W-1:0]   i_width,
    input  logic [csg_pkg::DIM_W-1:0]   i_height,
    input  logic [csg_pkg::STAB_W-1:0]  i_first_stab,
    input  logic [csg_pkg::STAB_W-1:0]  i_second_stab,
    input  logic                        i_stab_kind,
    output csg_pkg::t_status            o_status,
    output logic [csg_pkg::QUBIT_W-1:0] o_qubit_index,
    output logic                        o_pauli_kind,
    output logic                        o_no_flip,
    output logic                        o_last
);

    localparam int DW = csg_pkg::DIM_W;
    localparam int SW = csg_pkg::SITE_W;
    localparam int QW = csg_pkg::QUBIT_W;

    // One restoring division step: shift in the next dividend bit, subtract if it fits
    function automatic logic [DW+SW-1:0] div_step(
        input logic [DW-1:0] rm,
        input logic [SW-1:0] dv,
        input logic [DW-1:0] d
    );
        logic [DW:0]   t;
        logic          fits;
        logic [DW-1:0] rm_n;
        t    = {rm, dv[SW-1]};
        fits = (t >= {1'b0, d});
        rm_n = fits ? DW'(t - {1'b0, d}) : DW'(t);
        return {rm_n, dv[SW-2:0], fits};
    endfunction

    // 1 when the walk goes toward increasing coordinate
    function automatic logic pick_dir(
        input logic [DW-1:0] from,
        input logic [DW-1:0] to,
        input logic [DW-1:0] size
    );
        logic signed [DW+1:0] d;
        logic signed [DW+1:0] half;
        d    = $signed({2'b00, to}) - $signed({2'b00, from});
        half = $signed({2'b00, DW'(size >> 1)});
        return !((d > half) || ((d <= 0) && (-d < half)));
    endfunction

    logic [SW-1:0]   r_dv_a, r_dv_b;
    logic [DW-1:0]   r_rm_a, r_rm_b;
    logic            r_kind;
    logic [DW-1:0]   r_x1, r_x2, r_y1, r_y2;
    logic [DW-1:0]   r_cur_x, r_cur_y;
    logic            r_xd, r_yd;
    logic [QW-1:0]   r_base, r_wh;
    logic [QW-1:0]   r_q;
    logic            r_p, r_nf, r_last;

    logic [DW-1:0]      divisor;
    logic [DW+SW-1:0]   step_a, step_b;
    logic [2*DW-1:0]    wh_full, yw_full, row_full;
    logic [DW-1:0]      x_inc, x_dec, x_next, x_m;
    logic [DW-1:0]      y_inc, y_dec, y_next, y_m;
    logic [DW-1:0]      x2_p1;
    logic [QW-1:0]      q_x, q_y, col_add;

    // Division lanes
    assign divisor = i_cmd.div_by_h ? i_height : i_width;
    assign step_a  = div_step(r_rm_a, r_dv_a, divisor);
    assign step_b  = div_step(r_rm_b, r_dv_b, divisor);

    // Set-up products
    assign wh_full = i_width * i_height;
    assign yw_full = r_rm_a * i_width;

    // Column walk arithmetic
    assign x_inc  = (r_cur_x == i_width - 1'b1) ? '0 : r_cur_x + 1'b1;
    assign x_dec  = (r_cur_x == '0) ? i_width - 1'b1 : r_cur_x - 1'b1;
    assign x_next = r_xd ? x_inc : x_dec;
    assign x_m    = r_xd ? x_inc : r_cur_x;
    assign q_x    = r_base + QW'(x_m);

    // Row walk arithmetic
    assign y_inc  = (r_cur_y == i_height - 1'b1) ? '0 : r_cur_y + 1'b1;
    assign y_dec  = (r_cur_y == '0) ? i_height - 1'b1 : r_cur_y - 1'b1;
    assign y_next = r_yd ? y_inc : y_dec;
    assign y_m    = r_kind ? (r_yd ? r_cur_y : y_dec) : (r_yd ? y_inc : r_cur_y);
    assign x2_p1  = (r_x2 == i_width - 1'b1) ? '0 : r_x2 + 1'b1;
    assign row_full = y_m * i_width;
    assign col_add  = r_kind ? QW'(x2_p1) : QW'(r_x2) + r_wh;
    assign q_y      = QW'(row_full) + col_add;

    // Status to the controller
    assign o_status.coincide = (r_x1 == r_x2) && (r_y1 == r_y2);
    assign o_status.x_same   = (r_x1 == r_x2);
    assign o_status.y_same   = (r_y1 == r_y2);
    assign o_status.x_end    = (x_next == r_x2);
    assign o_status.y_end    = (y_next == r_y2);

    // Division and set-up registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dv_a <= i_first_stab[csg_pkg::STAB_W-1:1];
            r_dv_b <= i_second_stab[csg_pkg::STAB_W-1:1];
            r_rm_a <= '0;
            r_rm_b <= '0;
            r_kind <= i_stab_kind;
        end else if (i_cmd.div_step) begin
            r_rm_a <= step_a[DW+SW-1:SW];
            r_dv_a <= step_a[SW-1:0];
            r_rm_b <= step_b[DW+SW-1:SW];
            r_dv_b <= step_b[SW-1:0];
        end else if (i_cmd.latch_x) begin
            r_x1   <= r_rm_a;
            r_x2   <= r_rm_b;
            r_rm_a <= '0;
            r_rm_b <= '0;
        end else if (i_cmd.setup) begin
            r_y1    <= r_rm_a;
            r_y2    <= r_rm_b;
            r_cur_x <= r_x1;
            r_cur_y <= r_rm_a;
            r_xd    <= pick_dir(r_x1, r_x2, i_width);
            r_yd    <= pick_dir(r_rm_a, r_rm_b, i_height);
            r_wh    <= QW'(wh_full);
            r_base  <= QW'(yw_full) + (r_kind ? QW'(wh_full) : '0);
        end else if (i_cmd.emit_x) begin
            r_cur_x <= x_next;
        end else if (i_cmd.emit_y) begin
            r_cur_y <= y_next;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_nf) begin
            r_q    <= '0;
            r_p    <= csg_pkg::PAULI_Z;
            r_nf   <= 1'b1;
            r_last <= 1'b1;
        end else if (i_cmd.emit_x) begin
            r_q    <= q_x;
            r_p    <= csg_pkg::PAULI_Z;
            r_nf   <= 1'b0;
            r_last <= o_status.x_end && o_status.y_same;
        end else if (i_cmd.emit_y) begin
            r_q    <= q_y;
            r_p    <= csg_pkg::PAULI_X;
            r_nf   <= 1'b0;
            r_last <= o_status.y_end;
        end
    end

    assign o_qubit_index = r_q;
    assign o_pauli_kind  = r_p;
    assign o_no_flip     = r_nf;
    assign o_last        = r_last;

endmodule

>>> hdl/correction_string_generator_core.sv
// Top level of the correction string generator: registers, controller and datapath.
//
// Takes one matched stabilizer pair at a time and emits the qubits to toggle
// to join them on a W by H torus: first the Z run along the row of the first
// site, then the X run along the column of the second site, one result per
// cycle while the output is taken, with last on the final one (a coinciding
// pair gives a single no_flip result). Before the first result, a pair goes
// through the bit-serial division of both site indices, by W and then by H
// (10 steps each), and the set-up of the walk. The next pair is accepted
// once the last result of the current one has been loaded into the output
// register. Width and height are saturated into 2..32 when written; the
// user must write them only while no pair is in progress, as the block
// itself does not enforce this.
module correction_string_generator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [csg_pkg::ADDR_W-1:0]  paddr,
    input  logic [csg_pkg::DATA_W-1:0]  pwdata,
    output logic [csg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // Input pair
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [csg_pkg::STAB_W-1:0]  i_first_stab,
    input  logic [csg_pkg::STAB_W-1:0]  i_second_stab,
    input  logic                        i_stab_kind,
    // Result
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [csg_pkg::QUBIT_W-1:0] o_qubit_index,
    output logic                        o_pauli_kind,
    output logic                        o_no_flip,
    output logic                        o_last
);

    logic [csg_pkg::DIM_W-1:0] width;
    logic [csg_pkg::DIM_W-1:0] height;
    csg_pkg::t_cmd             cmd;
    csg_pkg::t_status          status;

    csg_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_width  (width),
        .o_height (height)
    );

    csg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    csg_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_width       (width),
        .i_height      (height),
        .i_first_stab  (i_first_stab),
        .i_second_stab (i_second_stab),
        .i_stab_kind   (i_stab_kind),
        .o_status      (status),
        .o_qubit_index (o_qubit_index),
        .o_pauli_kind  (o_pauli_kind),
        .o_no_flip     (o_no_flip),
        .o_last        (o_last)
    );

endmodule
